// ===== sv/mpe_pkg.sv =====
// Shared types and codes for the mouse packet to pointer event decoder.
// No dependencies; every other file of the block imports this package.
package mpe_pkg;

  localparam int OUT_POS_W = 12;
  localparam int LIMIT_W   = 12;
  localparam int NUM_BTN   = 3;

  typedef enum logic [0:0] {
    CMD_PACKET  = 1'b0,
    CMD_SET_POS = 1'b1
  } cmd_t;

  typedef enum logic [1:0] {
    EV_PASSIVE = 2'd0,
    EV_MOVE    = 2'd1,
    EV_PRESS   = 2'd2,
    EV_RELEASE = 2'd3
  } ev_kind_t;

  typedef enum logic [1:0] {
    BTN_NONE   = 2'd0,
    BTN_LEFT   = 2'd1,
    BTN_RIGHT  = 2'd2,
    BTN_MIDDLE = 2'd3
  } btn_t;

  // Register index, taken from the word address
  typedef enum logic [0:0] {
    REG_X_LIMIT = 1'b0,
    REG_Y_LIMIT = 1'b1
  } reg_idx_t;

  localparam logic [LIMIT_W-1:0] X_LIMIT_RST = 12'd639;
  localparam logic [LIMIT_W-1:0] Y_LIMIT_RST = 12'd479;
  localparam logic [31:0]        X_CENTER_RST = 32'd320;
  localparam logic [31:0]        Y_CENTER_RST = 32'd240;

  typedef struct packed {
    ev_kind_t         kind;
    btn_t             btn;
    logic [NUM_BTN-1:0] mask;
  } event_t;

  // All events caused by one packet; the position is shared by all of them
  typedef struct packed {
    event_t [NUM_BTN-1:0] ev;
    logic   [NUM_BTN-1:0] valid;
    logic   [OUT_POS_W-1:0] x;
    logic   [OUT_POS_W-1:0] y;
  } pkt_t;

  // Limit register write, also recenters the pointer on that axis
  typedef struct packed {
    logic               wr_x;
    logic               wr_y;
    logic [LIMIT_W-1:0] value;
  } cfg_wr_t;

  function automatic btn_t slot_button(input logic [1:0] slot);
    btn_t b;
    unique case (slot)
      2'd0:    b = BTN_LEFT;
      2'd1:    b = BTN_RIGHT;
      2'd2:    b = BTN_MIDDLE;
      default: b = BTN_NONE;
    endcase
    return b;
  endfunction

endpackage

// ===== sv/mpe_cfg_regs.sv =====
// Limit registers behind the APB-style configuration port.
// Depends on mpe_pkg for register indexes, reset values and the write struct.
module mpe_cfg_regs
  import mpe_pkg::*;
(
  input  logic               clk,
  input  logic               rst_n,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [2:0]         paddr,
  input  logic [31:0]        pwdata,
  output logic [31:0]        prdata,
  output logic               pready,
  output logic [LIMIT_W-1:0] x_limit,
  output logic [LIMIT_W-1:0] y_limit,
  output cfg_wr_t            cfg_wr
);

  logic [LIMIT_W-1:0] x_limit_r, x_limit_nxt;
  logic [LIMIT_W-1:0] y_limit_r, y_limit_nxt;
  logic               wr_en;
  reg_idx_t           idx;

  assign pready = 1'b1;
  assign wr_en  = psel & penable & pwrite & pready;
  assign idx    = reg_idx_t'(paddr[2]);

  always_comb begin
    cfg_wr       = '0;
    cfg_wr.value = pwdata[LIMIT_W-1:0];
    x_limit_nxt  = x_limit_r;
    y_limit_nxt  = y_limit_r;
    if (wr_en) begin
      unique case (idx)
        REG_X_LIMIT: begin
          cfg_wr.wr_x = 1'b1;
          x_limit_nxt = pwdata[LIMIT_W-1:0];
        end
        REG_Y_LIMIT: begin
          cfg_wr.wr_y = 1'b1;
          y_limit_nxt = pwdata[LIMIT_W-1:0];
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      x_limit_r <= X_LIMIT_RST;
      y_limit_r <= Y_LIMIT_RST;
    end else begin
      x_limit_r <= x_limit_nxt;
      y_limit_r <= y_limit_nxt;
    end
  end

  always_comb begin
    unique case (idx)
      REG_X_LIMIT: prdata = {{(32-LIMIT_W){1'b0}}, x_limit_r};
      REG_Y_LIMIT: prdata = {{(32-LIMIT_W){1'b0}}, y_limit_r};
      default:     prdata = '0;
    endcase
  end

  assign x_limit = x_limit_r;
  assign y_limit = y_limit_r;

endmodule

// ===== sv/mpe_event_gen.sv =====
// Pointer and button state; turns one accepted packet into its list of events.
// Depends on mpe_pkg for command codes, event types and the config write struct.
module mpe_event_gen
  import mpe_pkg::*;
#(
  parameter int POS_BITS = 12
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               accept,
  input  logic [0:0]         cmd,
  input  logic [2:0]         button_bits,
  input  logic signed [7:0]  delta_x,
  input  logic signed [7:0]  delta_y,
  input  logic [11:0]        new_x,
  input  logic [11:0]        new_y,
  input  logic [LIMIT_W-1:0] x_limit,
  input  logic [LIMIT_W-1:0] y_limit,
  input  cfg_wr_t            cfg_wr,
  output pkt_t               pkt,
  output logic               pkt_load
);

  localparam int SUM_W = POS_BITS + 2;
  localparam logic [POS_BITS-1:0] POS_MAX = '1;

  logic [POS_BITS-1:0] pos_x_r, pos_x_nxt;
  logic [POS_BITS-1:0] pos_y_r, pos_y_nxt;
  logic [NUM_BTN-1:0]  held_r, held_nxt;
  logic [POS_BITS-1:0] mv_x, mv_y;
  logic [POS_BITS-1:0] center;
  logic [NUM_BTN-1:0]  changed;
  logic                is_set_pos;

  function automatic logic [POS_BITS-1:0] to_pos(input logic [31:0] v);
    return v[POS_BITS-1:0];
  endfunction

  function automatic logic [OUT_POS_W-1:0] to_out(input logic [POS_BITS-1:0] p);
    logic [31:0] w;
    w = 32'(p);
    return w[OUT_POS_W-1:0];
  endfunction

  // Add a signed byte delta and clamp to 0..limit (limit saturated to POS_MAX)
  function automatic logic [POS_BITS-1:0] move_axis(
    input logic [POS_BITS-1:0] pos,
    input logic signed [7:0]   d,
    input logic [LIMIT_W-1:0]  lim
  );
    logic [31:0]         lim32;
    logic [POS_BITS-1:0] top;
    logic signed [SUM_W-1:0] sum;
    logic [SUM_W-1:0]    sum_u;
    logic [POS_BITS-1:0] res;
    lim32 = 32'(lim);
    top   = (lim32 > 32'(POS_MAX)) ? POS_MAX : lim32[POS_BITS-1:0];
    sum   = $signed({2'b00, pos}) + SUM_W'(d);
    sum_u = sum;
    priority if (sum[SUM_W-1]) begin
      res = '0;
    end else if (sum_u > {2'b00, top}) begin
      res = top;
    end else begin
      res = sum_u[POS_BITS-1:0];
    end
    return res;
  endfunction

  assign is_set_pos = (cmd_t'(cmd) == CMD_SET_POS);
  assign mv_x       = move_axis(pos_x_r, delta_x, x_limit);
  assign mv_y       = move_axis(pos_y_r, delta_y, y_limit);
  assign center     = to_pos(32'((13'(cfg_wr.value) + 13'd1) >> 1));
  assign changed    = button_bits ^ held_r;

  always_comb begin
    pos_x_nxt = pos_x_r;
    pos_y_nxt = pos_y_r;
    held_nxt  = held_r;
    priority if (cfg_wr.wr_x || cfg_wr.wr_y) begin
      if (cfg_wr.wr_x) pos_x_nxt = center;
      if (cfg_wr.wr_y) pos_y_nxt = center;
    end else if (accept && is_set_pos) begin
      pos_x_nxt = to_pos(32'(new_x));
      pos_y_nxt = to_pos(32'(new_y));
    end else if (accept) begin
      pos_x_nxt = mv_x;
      pos_y_nxt = mv_y;
      held_nxt  = button_bits;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_x_r <= to_pos(X_CENTER_RST);
      pos_y_r <= to_pos(Y_CENTER_RST);
      held_r  <= '0;
    end else begin
      pos_x_r <= pos_x_nxt;
      pos_y_r <= pos_y_nxt;
      held_r  <= held_nxt;
    end
  end

  // Each button event carries the mask updated through that button
  always_comb begin
    logic [NUM_BTN-1:0] low;
    low   = '0;
    pkt   = '0;
    pkt.x = to_out(mv_x);
    pkt.y = to_out(mv_y);
    if (changed == '0) begin
      pkt.ev[0].kind = (held_r == '0) ? EV_PASSIVE : EV_MOVE;
      pkt.ev[0].btn  = BTN_NONE;
      pkt.ev[0].mask = held_r;
      pkt.valid      = 3'b001;
    end else begin
      for (int i = 0; i < NUM_BTN; i++) begin
        low = NUM_BTN'((4'd2 << i) - 4'd1);
        pkt.ev[i].kind = button_bits[i] ? EV_PRESS : EV_RELEASE;
        pkt.ev[i].btn  = slot_button(2'(i));
        pkt.ev[i].mask = (button_bits & low) | (held_r & ~low);
      end
      pkt.valid = changed;
    end
  end

  assign pkt_load = accept & ~is_set_pos;

`ifndef SYNTHESIS
  a_held_follows_packet: assert property (@(posedge clk) disable iff (!rst_n)
    accept && !is_set_pos && !cfg_wr.wr_x && !cfg_wr.wr_y
    |=> held_r == $past(button_bits))
    else $error("held mask not updated from packet");

  a_set_pos_keeps_held: assert property (@(posedge clk) disable iff (!rst_n)
    accept && is_set_pos |=> held_r == $past(held_r))
    else $error("set-position changed held mask");
`endif

endmodule

// ===== sv/mpe_event_queue.sv =====
// Result register for one packet's events; sends them out one per transfer.
// Depends on mpe_pkg for the packet and event types.
module mpe_event_queue
  import mpe_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst_n,
  input  pkt_t                 pkt_in,
  input  logic                 load,
  output logic                 can_load,
  output logic                 out_valid,
  input  logic                 out_stall,
  output logic [1:0]           out_event_kind,
  output logic [1:0]           out_which_button,
  output logic [2:0]           out_held_mask,
  output logic [OUT_POS_W-1:0] out_pos_x,
  output logic [OUT_POS_W-1:0] out_pos_y,
  output logic                 out_last_event
);

  pkt_t               pkt_r;
  logic [NUM_BTN-1:0] pend_r, pend_nxt;
  logic [NUM_BTN-1:0] sel;
  event_t             cur;
  logic               xfer;
  logic               last;

  assign sel       = pend_r & (~pend_r + NUM_BTN'(1));
  assign last      = (pend_r & ~sel) == '0;
  assign out_valid = pend_r != '0;
  assign xfer      = out_valid & ~out_stall;
  assign can_load  = !out_valid || (xfer && last);

  always_comb begin
    priority if (pend_r[0]) begin
      cur = pkt_r.ev[0];
    end else if (pend_r[1]) begin
      cur = pkt_r.ev[1];
    end else begin
      cur = pkt_r.ev[2];
    end
  end

  always_comb begin
    pend_nxt = pend_r;
    if (xfer) pend_nxt = pend_r & ~sel;
    if (load) pend_nxt = pkt_in.valid;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pend_r <= '0;
    end else begin
      pend_r <= pend_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (load) pkt_r <= pkt_in;
  end

  assign out_event_kind   = cur.kind;
  assign out_which_button = cur.btn;
  assign out_held_mask    = cur.mask;
  assign out_pos_x        = pkt_r.x;
  assign out_pos_y        = pkt_r.y;
  assign out_last_event   = last;

`ifndef SYNTHESIS
  a_load_only_when_free: assert property (@(posedge clk) disable iff (!rst_n)
    load |-> (pend_r == '0) || (xfer && last))
    else $error("packet loaded over pending events");

  a_load_shows_event: assert property (@(posedge clk) disable iff (!rst_n)
    load && (pkt_in.valid != '0) |=> out_valid)
    else $error("loaded packet produced no event");

  a_last_drains: assert property (@(posedge clk) disable iff (!rst_n)
    xfer && last && !load |=> !out_valid)
    else $error("events left after last transfer");
`endif

endmodule

// ===== sv/mouse_packet_to_events.sv =====
// Mouse packet decoder: each transfer in is a three-byte mouse packet or a
// set-position command. A packet moves the pointer (clamped to 0..limit on each
// axis) and yields one to three events, one per result transfer: one passive or
// move event when the buttons did not change, else one press or release per
// changed button in the order left, right, middle, the final one flagged by
// out_last_event. The event register sends one event per cycle while out_stall
// is low, so a packet occupies the output until its last event leaves; the next
// item is taken in the same cycle as the last event of the previous packet
// leaves. A set-position command gives no event. Writing a limit register
// recenters the pointer on that axis; write only while idle.
module mouse_packet_to_events
  import mpe_pkg::*;
#(
  parameter int POS_BITS = 12
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_stall,
  input  logic [0:0]           in_cmd,
  input  logic [2:0]           in_button_bits,
  input  logic signed [7:0]    in_delta_x,
  input  logic signed [7:0]    in_delta_y,
  input  logic [11:0]          in_new_x,
  input  logic [11:0]          in_new_y,
  output logic                 out_valid,
  input  logic                 out_stall,
  output logic [1:0]           out_event_kind,
  output logic [1:0]           out_which_button,
  output logic [2:0]           out_held_mask,
  output logic [OUT_POS_W-1:0] out_pos_x,
  output logic [OUT_POS_W-1:0] out_pos_y,
  output logic                 out_last_event,
  input  logic                 psel,
  input  logic                 penable,
  input  logic                 pwrite,
  input  logic [2:0]           paddr,
  input  logic [31:0]          pwdata,
  output logic [31:0]          prdata,
  output logic                 pready
);

  logic [LIMIT_W-1:0] x_limit;
  logic [LIMIT_W-1:0] y_limit;
  cfg_wr_t            cfg_wr;
  pkt_t               pkt;
  logic               pkt_load;
  logic               can_load;
  logic               accept;

  assign in_stall = ~can_load;
  assign accept   = in_valid & can_load;

  mpe_cfg_regs u_regs (
    .clk     (clk),
    .rst_n   (rst_n),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .x_limit (x_limit),
    .y_limit (y_limit),
    .cfg_wr  (cfg_wr)
  );

  mpe_event_gen #(
    .POS_BITS (POS_BITS)
  ) u_gen (
    .clk         (clk),
    .rst_n       (rst_n),
    .accept      (accept),
    .cmd         (in_cmd),
    .button_bits (in_button_bits),
    .delta_x     (in_delta_x),
    .delta_y     (in_delta_y),
    .new_x       (in_new_x),
    .new_y       (in_new_y),
    .x_limit     (x_limit),
    .y_limit     (y_limit),
    .cfg_wr      (cfg_wr),
    .pkt         (pkt),
    .pkt_load    (pkt_load)
  );

  mpe_event_queue u_queue (
    .clk              (clk),
    .rst_n            (rst_n),
    .pkt_in           (pkt),
    .load             (pkt_load),
    .can_load         (can_load),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_event_kind   (out_event_kind),
    .out_which_button (out_which_button),
    .out_held_mask    (out_held_mask),
    .out_pos_x        (out_pos_x),
    .out_pos_y        (out_pos_y),
    .out_last_event   (out_last_event)
  );

endmodule
